@@ design/psem_pkg.sv @@
package psem_pkg;

   // field widths fixed by the interface
   localparam int OPCODE_W   = 2;
   localparam int TASK_ID_W  = 8;
   localparam int PRIO_W     = 2;
   localparam int STATUS_W   = 3;
   localparam int COUNT_W    = 8;

   typedef logic [OPCODE_W-1:0]  opcode_type;
   typedef logic [TASK_ID_W-1:0] task_id_type;
   typedef logic [PRIO_W-1:0]    prio_type;
   typedef logic [STATUS_W-1:0]  status_type;
   typedef logic [COUNT_W-1:0]   count_type;

   // opcodes
   localparam opcode_type OP_TAKE    = 2'd0;
   localparam opcode_type OP_RELEASE = 2'd1;
   localparam opcode_type OP_RETRY   = 2'd2;

   // result status codes
   localparam status_type ST_GRANTED  = 3'd0;
   localparam status_type ST_QUEUED   = 3'd1;
   localparam status_type ST_DROPPED  = 3'd2;
   localparam status_type ST_REFUSED  = 3'd3;
   localparam status_type ST_REL_NONE = 3'd4;
   localparam status_type ST_REL_WOKE = 3'd5;

   localparam count_type COUNT_MAX   = 8'hFF;
   localparam count_type COUNT_RESET = 8'd1;

   // parameter defaults
   localparam int PRIORITY_LEVELS_DEF = 4;
   localparam int QUEUE_DEPTH_DEF     = 8;
   localparam int TASK_ID_BITS_DEF    = 8;

   typedef struct packed {
      opcode_type  opcode;
      task_id_type task_id;
      prio_type    task_priority;
   } req_type;

   typedef struct packed {
      status_type  status;
      task_id_type woken_task;
      logic        woken_valid;
      count_type   count_after;
   } rsp_type;

endpackage

@@ design/psem_store.sv @@
// Single-port wait store, registered read.
module psem_store #(
   parameter int  DEPTH  = 32,
   parameter int  DATA_W = 8,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              en,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wdata,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en && we) begin
         mem[addr] <= wdata;
      end
      if (en && !we) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ design/priority_wait_semaphore.sv @@
// Counting semaphore with one FIFO wait ring per priority level. One request beat is
// handled at a time: a take or retry is accepted, then executed; a release is accepted,
// then the sequencer tests one level's fill counter per cycle from level 0 upward and,
// when it finds a waiter, reads the oldest one through the registered read of the
// single-port wait store. A result is written only once the response register is free.
// A finished result sits in the response register, so the next request is taken while it
// waits. The wait store is not cleared after reset; ring counters are.
module priority_wait_semaphore #(
   parameter int PRIORITY_LEVELS = psem_pkg::PRIORITY_LEVELS_DEF,
   parameter int QUEUE_DEPTH     = psem_pkg::QUEUE_DEPTH_DEF,
   parameter int TASK_ID_BITS    = psem_pkg::TASK_ID_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  psem_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output psem_pkg::rsp_type   rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  psem_pkg::count_type csr_data
);

   localparam int LVL_W  = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int NUM_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int SLOTS  = PRIORITY_LEVELS * QUEUE_DEPTH;
   localparam int ADDR_W = $clog2(SLOTS);

   // one-hot sequencer
   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,   // wait for a request or csr beat
      S_EXEC = 4'b0010,   // take / retry / unused opcode
      S_SCAN = 4'b0100,   // release: test one level per cycle
      S_READ = 4'b1000    // release: wait store data back
   } state_type;

   state_type state_ff, state_in;

   psem_pkg::opcode_type op_ff, op_in;
   logic [TASK_ID_BITS-1:0] id_ff, id_in;
   logic prio_ok_ff, prio_ok_in;
   logic [LVL_W-1:0] level_ff, level_in;
   psem_pkg::count_type count_ff, count_in;

   // per-level ring state, always addressed through level_ff
   logic [PTR_W-1:0] head_ff [PRIORITY_LEVELS];
   logic [PTR_W-1:0] head_in [PRIORITY_LEVELS];
   logic [PTR_W-1:0] tail_ff [PRIORITY_LEVELS];
   logic [PTR_W-1:0] tail_in [PRIORITY_LEVELS];
   logic [NUM_W-1:0] num_ff  [PRIORITY_LEVELS];
   logic [NUM_W-1:0] num_in  [PRIORITY_LEVELS];

   psem_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   // wait store port
   logic mem_en, mem_we;
   logic [ADDR_W-1:0] mem_addr;
   logic [PTR_W-1:0] mem_ptr;
   logic [TASK_ID_BITS-1:0] mem_rdata;

   logic out_free;
   logic [NUM_W-1:0] cur_num;
   logic [PTR_W-1:0] cur_head, cur_tail, next_tail;
   logic last_level;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign cur_num    = num_ff[level_ff];
   assign cur_head   = head_ff[level_ff];
   assign cur_tail   = tail_ff[level_ff];
   assign next_tail  = (cur_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : cur_tail + 1'b1;
   assign last_level = (level_ff == LVL_W'(PRIORITY_LEVELS - 1));

   // csr beats go first; only taken while idle
   assign csr_ready = (state_ff == S_IDLE);
   assign req_ready = (state_ff == S_IDLE) && !csr_valid;

   assign mem_addr = ADDR_W'(level_ff) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(mem_ptr);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      id_in        = id_ff;
      prio_ok_in   = prio_ok_ff;
      level_in     = level_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      num_in       = num_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_en       = 1'b0;
      mem_we       = 1'b0;
      mem_ptr      = cur_head;

      case (state_ff)
         S_IDLE: begin
            if (csr_valid) begin
               count_in = csr_data;
            end else if (req_valid) begin
               op_in      = req_data.opcode;
               id_in      = TASK_ID_BITS'(req_data.task_id);
               prio_ok_in = (int'(req_data.task_priority) < PRIORITY_LEVELS);
               if (req_data.opcode == psem_pkg::OP_RELEASE) begin
                  // count is bumped now, the scan only moves waiters
                  if (count_ff != psem_pkg::COUNT_MAX) begin
                     count_in = count_ff + 1'b1;
                  end
                  level_in = '0;
                  state_in = S_SCAN;
               end else begin
                  level_in = prio_ok_in ? LVL_W'(req_data.task_priority) : '0;
                  state_in = S_EXEC;
               end
            end
         end

         S_EXEC: begin
            if (out_free) begin
               rsp_in.status = psem_pkg::ST_REFUSED;
               if (op_ff == psem_pkg::OP_TAKE || op_ff == psem_pkg::OP_RETRY) begin
                  if (count_ff != '0) begin
                     count_in      = count_ff - 1'b1;
                     rsp_in.status = psem_pkg::ST_GRANTED;
                  end else if (op_ff == psem_pkg::OP_RETRY) begin
                     rsp_in.status = psem_pkg::ST_REFUSED;
                  end else if (!prio_ok_ff) begin
                     rsp_in.status = psem_pkg::ST_DROPPED;
                  end else if (cur_num == '0) begin
                     // empty ring restarts at slot 0
                     head_in[level_ff] = '0;
                     tail_in[level_ff] = '0;
                     num_in[level_ff]  = NUM_W'(1);
                     mem_ptr           = '0;
                     mem_en            = 1'b1;
                     mem_we            = 1'b1;
                     rsp_in.status     = psem_pkg::ST_QUEUED;
                  end else if (cur_num < NUM_W'(QUEUE_DEPTH)) begin
                     tail_in[level_ff] = next_tail;
                     num_in[level_ff]  = cur_num + 1'b1;
                     mem_ptr           = next_tail;
                     mem_en            = 1'b1;
                     mem_we            = 1'b1;
                     rsp_in.status     = psem_pkg::ST_QUEUED;
                  end else begin
                     rsp_in.status = psem_pkg::ST_DROPPED;
                  end
               end
               rsp_in.woken_task  = '0;
               rsp_in.woken_valid = 1'b0;
               rsp_in.count_after = count_in;
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end
         end

         S_SCAN: begin
            if (cur_num != '0) begin
               // oldest waiter of this level
               mem_ptr           = cur_head;
               mem_en            = 1'b1;
               head_in[level_ff] = (cur_head == PTR_W'(QUEUE_DEPTH - 1)) ?
                                   '0 : cur_head + 1'b1;
               num_in[level_ff]  = cur_num - 1'b1;
               state_in          = S_READ;
            end else if (last_level) begin
               if (out_free) begin
                  rsp_in.status      = psem_pkg::ST_REL_NONE;
                  rsp_in.woken_task  = '0;
                  rsp_in.woken_valid = 1'b0;
                  rsp_in.count_after = count_ff;
                  rsp_valid_in       = 1'b1;
                  state_in           = S_IDLE;
               end
            end else begin
               level_in = level_ff + 1'b1;
            end
         end

         S_READ: begin
            if (out_free) begin
               rsp_in.status      = psem_pkg::ST_REL_WOKE;
               rsp_in.woken_task  = psem_pkg::task_id_type'(mem_rdata);
               rsp_in.woken_valid = 1'b1;
               rsp_in.count_after = count_ff;
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= psem_pkg::COUNT_RESET;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '{default: '0};
         tail_ff      <= '{default: '0};
         num_ff       <= '{default: '0};
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         num_ff       <= num_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      id_ff      <= id_in;
      prio_ok_ff <= prio_ok_in;
      level_ff   <= level_in;
      rsp_ff     <= rsp_in;
   end

   psem_store #(
      .DEPTH  (SLOTS),
      .DATA_W (TASK_ID_BITS)
   ) u_store (
      .clock (clock),
      .en    (mem_en),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (id_ff),
      .rdata (mem_rdata)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ design/psem_checker.sv @@
// Port-level checks for the semaphore.
module psem_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input psem_pkg::rsp_type   rsp_data,
   input logic                csr_ready
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   // woken flag matches status
   a_woken_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.woken_valid == (rsp_data.status == psem_pkg::ST_REL_WOKE)))
      else $error("woken_valid disagrees with status");

   // no woken id without a waiter
   a_woken_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.woken_valid |-> rsp_data.woken_task == '0)
      else $error("woken_task set without waiter");

   // one request in flight
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !csr_ready)
      else $error("request taken while busy");

   // a grant never reports a full count
   a_grant_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == psem_pkg::ST_GRANTED |->
      rsp_data.count_after != psem_pkg::COUNT_MAX)
      else $error("granted with full count");

endmodule

bind priority_wait_semaphore psem_checker u_psem_checker (.*);
